/* hdl/scrs_pkg.sv */
// ----------------------------------------------------------------------------
// Shift chain reader sequencer package
// Phase codes, register indexes, sequencer state and result word types.
// ----------------------------------------------------------------------------
package scrs_pkg;

  localparam int unsigned MaxFrameBits = 256;
  localparam int unsigned PeriodW      = 16;
  localparam int unsigned FrameW       = 9;
  localparam int unsigned ElapsedW     = 17;
  localparam int unsigned IndexW       = 8;
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};
  localparam logic [FrameW-1:0]   FrameCap   =
      (MaxFrameBits >= (2 ** FrameW) - 1) ? {FrameW{1'b1}} : FrameW'(MaxFrameBits);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLOCK_PERIOD = 2'd0,
    CFG_RESET_PERIOD = 2'd1,
    CFG_FRAME_LENGTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_HIGH      = 4'd0,
    PH_LOW       = 4'd1,
    PH_SAMPLE    = 4'd2,
    PH_R1        = 4'd3,
    PH_R2        = 4'd4,
    PH_R3        = 4'd5,
    PH_R4        = 4'd6,
    PH_R5        = 4'd7,
    PH_R6        = 4'd8,
    PH_R6_SAMPLE = 4'd9
  } phase_e;

  typedef struct packed {
    phase_e               phase;
    logic [FrameW-1:0]    next_bit;
    logic [ElapsedW-1:0]  elapsed;
    logic [PeriodW-1:0]   duration;
    logic                 clock_line;
    logic                 load_line;
    logic                 clear_line;
  } seq_state_t;

  // lowest bit last: clock_level is bit 0
  typedef struct packed {
    logic                 chain_reloaded;
    logic                 bit_value;
    logic [IndexW-1:0]    bit_index;
    logic                 bit_valid;
    logic                 clear_level;
    logic                 load_level;
    logic                 clock_level;
  } result_t;

endpackage

/* hdl/shift_chain_reader_sequencer.sv */
// ----------------------------------------------------------------------------
// Shift chain reader sequencer
// Drives clock, load and clear of a parallel-in serial-out chain, samples data.
// ----------------------------------------------------------------------------
// Each input word is one tick carrying the serial data level; each accepted
// word yields exactly one result word through the output register, and a new word is
// taken every cycle while the output register is empty or being drained.
// The rate is one word per cycle unless the output stalls, set by the
// combinational phase counter compare and transition in scrs_step.
// A frame_length write restarts the sequencer at its reload decision.
module shift_chain_reader_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [scrs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [scrs_pkg::PeriodW-1:0]     cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [0] data_in
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] clock_level, [1] load_level, [2] clear_level, [3] bit_valid,
  // [11:4] bit_index, [12] bit_value, [13] chain_reloaded
  output logic [15:0]                      m_axis_tdata
);
  import scrs_pkg::*;

  logic [PeriodW-1:0] clock_period_q;
  logic [PeriodW-1:0] reset_period_q;
  logic [FrameW-1:0]  frame_length_q;
  logic [FrameW-1:0]  frame_wr;
  seq_state_t         state_q, state_d, state_step;
  result_t            result_q, result_step;
  logic               out_valid_q;
  logic               in_fire, cfg_fire;

  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, result_q};

  assign frame_wr = (cfg_data_i[FrameW-1:0] > FrameCap) ? FrameCap
                                                         : cfg_data_i[FrameW-1:0];

  scrs_step u_step (
    .state_i        (state_q),
    .frame_length_i (frame_length_q),
    .clock_period_i (clock_period_q),
    .reset_period_i (reset_period_q),
    .data_i         (s_axis_tdata[0]),
    .state_o        (state_step),
    .result_o       (result_step)
  );

  always_comb begin
    state_d = state_q;
    if (cfg_fire && cfg_index_i == CFG_FRAME_LENGTH) begin
      state_d.phase    = PH_SAMPLE;
      state_d.next_bit = frame_wr;
      state_d.duration = '0;
      state_d.elapsed  = ElapsedMax;
    end else if (in_fire) begin
      state_d = state_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_period_q     <= PeriodW'(10);
      reset_period_q     <= PeriodW'(10);
      frame_length_q     <= FrameW'(8);
      state_q.phase      <= PH_SAMPLE;
      state_q.next_bit   <= FrameW'(8);
      state_q.elapsed    <= ElapsedMax;
      state_q.duration   <= '0;
      state_q.clock_line <= 1'b0;
      state_q.load_line  <= 1'b0;
      state_q.clear_line <= 1'b0;
      out_valid_q        <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_CLOCK_PERIOD: clock_period_q <= cfg_data_i;
          CFG_RESET_PERIOD: reset_period_q <= cfg_data_i;
          CFG_FRAME_LENGTH: frame_length_q <= frame_wr;
          default: ;
        endcase
      end
      state_q <= state_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_step;
    end
  end

endmodule

/* hdl/scrs_step.sv */
// ----------------------------------------------------------------------------
// Shift chain reader sequencer step
// Next sequencer state and result word for one tick.
// ----------------------------------------------------------------------------
module scrs_step (
  input  scrs_pkg::seq_state_t              state_i,
  input  logic [scrs_pkg::FrameW-1:0]       frame_length_i,
  input  logic [scrs_pkg::PeriodW-1:0]      clock_period_i,
  input  logic [scrs_pkg::PeriodW-1:0]      reset_period_i,
  input  logic                              data_i,
  output scrs_pkg::seq_state_t              state_o,
  output scrs_pkg::result_t                 result_o
);
  import scrs_pkg::*;

  logic [ElapsedW-1:0] elapsed_inc;
  logic                fire;
  phase_e              phase_nx;
  logic [FrameW-1:0]   bit_nx;

  assign elapsed_inc = (state_i.elapsed == ElapsedMax) ? state_i.elapsed
                                                       : state_i.elapsed + 1'b1;
  assign fire = elapsed_inc > {1'b0, state_i.duration};

  always_comb begin
    phase_nx = PH_HIGH;
    bit_nx   = state_i.next_bit;
    case (state_i.phase)
      PH_HIGH:   phase_nx = PH_LOW;
      PH_LOW:    phase_nx = PH_SAMPLE;
      PH_SAMPLE: begin
        if (state_i.next_bit < frame_length_i) begin
          phase_nx = PH_HIGH;
        end else begin
          phase_nx = PH_R1;
          bit_nx   = '0;
        end
      end
      PH_R1:     phase_nx = PH_R2;
      PH_R2:     phase_nx = PH_R3;
      PH_R3:     phase_nx = PH_R4;
      PH_R4:     phase_nx = PH_R5;
      PH_R5:     phase_nx = PH_R6;
      PH_R6:     phase_nx = PH_R6_SAMPLE;
      default:   phase_nx = PH_HIGH;
    endcase
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    state_o.elapsed = elapsed_inc;
    if (fire) begin
      state_o.phase    = phase_nx;
      state_o.next_bit = bit_nx;
      state_o.elapsed  = '0;
      case (phase_nx)
        PH_HIGH: state_o.clock_line = 1'b1;
        PH_LOW:  state_o.clock_line = 1'b0;
        PH_R1: begin
          state_o.clock_line = 1'b0;
          state_o.load_line  = 1'b1;
        end
        PH_R2:   state_o.clock_line = 1'b1;
        PH_R3:   state_o.clock_line = 1'b0;
        PH_R4:   state_o.clear_line = 1'b1;
        PH_R5:   state_o.clear_line = 1'b0;
        PH_R6:   state_o.load_line  = 1'b0;
        default: ;
      endcase
      case (phase_nx)
        PH_HIGH:                          state_o.duration = clock_period_i;
        PH_LOW, PH_SAMPLE:                state_o.duration = clock_period_i >> 1;
        PH_R1, PH_R2, PH_R3, PH_R4, PH_R5: state_o.duration = reset_period_i;
        default:                          state_o.duration = reset_period_i >> 1;
      endcase
      if (phase_nx == PH_SAMPLE || phase_nx == PH_R6_SAMPLE) begin
        result_o.bit_valid = 1'b1;
        result_o.bit_index = bit_nx[IndexW-1:0];
        result_o.bit_value = data_i;
        state_o.next_bit   = bit_nx + 1'b1;
      end
      result_o.chain_reloaded = (phase_nx == PH_R1);
    end
    result_o.clock_level = state_o.clock_line;
    result_o.load_level  = state_o.load_line;
    result_o.clear_level = state_o.clear_line;
  end

endmodule
